// ===== rtl/tfpt_pkg.sv =====
`timescale 1ns / 1ps

package tfpt_pkg;

  localparam int unsigned AddrBits          = 16;
  localparam int unsigned OffsetBits        = 8;
  localparam int unsigned PageBits          = 8;
  localparam int unsigned FrameBits         = 8;
  localparam int unsigned PageCount         = 256;
  localparam int unsigned FrameCount        = 256;
  localparam int unsigned TlbEntriesDefault = 16;
  localparam int unsigned CountBits         = 9;
  localparam int unsigned PaddrBits         = 3;
  localparam int unsigned PdataBits         = 32;

  localparam logic [CountBits-1:0] FrameCountReset = 9'd256;
  localparam logic [CountBits-1:0] FrameCountMax   = 9'd256;
  localparam logic [CountBits-1:0] FrameCountMin   = 9'd1;

  typedef enum logic [0:0] {
    RegFrameCount = 1'b0
  } cfg_reg_e;

  typedef struct packed {
    logic                 valid;
    logic [FrameBits-1:0] frame;
  } map_entry_t;

  typedef struct packed {
    logic                valid;
    logic [PageBits-1:0] page;
  } owner_entry_t;

  typedef struct packed {
    logic                en;
    logic [PageBits-1:0] addr;
    map_entry_t          data;
  } map_wr_t;

  typedef struct packed {
    logic                 en;
    logic [FrameBits-1:0] addr;
    owner_entry_t         data;
  } owner_wr_t;

  typedef struct packed {
    logic                en;
    logic [PageBits-1:0] tag;
  } tlb_lookup_t;

  typedef struct packed {
    logic                 en;
    logic [PageBits-1:0]  tag;
    logic [FrameBits-1:0] frame;
  } tlb_push_t;

  typedef struct packed {
    logic                 hit;
    logic [FrameBits-1:0] frame;
  } tlb_result_t;

  typedef struct packed {
    logic [AddrBits-1:0] physical_address;
    logic                tlb_hit;
    logic                page_fault;
  } xlat_t;

endpackage

// ===== rtl/tfpt_if.sv =====
`timescale 1ns / 1ps

interface tfpt_req_if import tfpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AddrBits-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

interface tfpt_rsp_if import tfpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [AddrBits-1:0] physical_address;
  logic                tlb_hit;
  logic                page_fault;

  modport source (output valid, output physical_address, output tlb_hit, output page_fault,
                  input ready);
  modport sink (input valid, input physical_address, input tlb_hit, input page_fault,
                output ready);
endinterface

// ===== rtl/tfpt_cfg_apb.sv =====
`timescale 1ns / 1ps

module tfpt_cfg_apb import tfpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  output logic [PdataBits-1:0] prdata,
  output logic                 pready,
  output logic [CountBits-1:0] frame_count_o
);

  logic [CountBits-1:0] frame_count_q;
  logic [CountBits-1:0] frame_count_d;
  logic                 wr_en;
  cfg_reg_e             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[PaddrBits-1]);

  always_comb begin
    frame_count_d = frame_count_q;
    prdata        = '0;
    case (reg_sel)
      RegFrameCount: begin
        prdata = PdataBits'(frame_count_q);
        if (wr_en) begin
          frame_count_d = pwdata[CountBits-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FrameCountReset;
    end else begin
      frame_count_q <= frame_count_d;
    end
  end

  assign frame_count_o = frame_count_q;

endmodule

// ===== rtl/tfpt_tlb.sv =====
`timescale 1ns / 1ps

module tfpt_tlb import tfpt_pkg::*; #(
  parameter int unsigned TlbEntries = TlbEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tlb_lookup_t lookup_i,
  input  tlb_push_t   push_i,
  output tlb_result_t result_o
);

  logic [PageBits-1:0]   tag_q   [TlbEntries];
  logic [FrameBits-1:0]  frame_q [TlbEntries];
  logic [TlbEntries-1:0] valid_q;
  logic [TlbEntries-1:0] match_q;
  logic [TlbEntries-1:0] match_d;

  always_comb begin
    for (int i = 0; i < TlbEntries; i++) begin
      match_d[i] = valid_q[i] && (tag_q[i] == lookup_i.tag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      match_q <= '0;
    end else begin
      if (push_i.en) begin
        valid_q <= {1'b1, valid_q[TlbEntries-1:1]};
      end
      if (lookup_i.en) begin
        match_q <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.en) begin
      for (int i = 0; i < TlbEntries - 1; i++) begin
        tag_q[i]   <= tag_q[i+1];
        frame_q[i] <= frame_q[i+1];
      end
      tag_q[TlbEntries-1]   <= push_i.tag;
      frame_q[TlbEntries-1] <= push_i.frame;
    end
  end

  // The newest matching slot wins, so the highest index is taken last.
  always_comb begin
    result_o.hit   = |match_q;
    result_o.frame = '0;
    for (int i = 0; i < TlbEntries; i++) begin
      if (match_q[i]) begin
        result_o.frame = frame_q[i];
      end
    end
  end

endmodule

// ===== rtl/tfpt_page_mem.sv =====
`timescale 1ns / 1ps

module tfpt_page_mem import tfpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [PageBits-1:0]  map_raddr_i,
  input  map_wr_t              map_wr_i,
  output map_entry_t           map_rdata_o,
  input  logic [FrameBits-1:0] owner_raddr_i,
  input  owner_wr_t            owner_wr_i,
  output owner_entry_t         owner_rdata_o,
  output logic                 clearing_o
);

  localparam int unsigned ClrDepth = (PageCount > FrameCount) ? PageCount : FrameCount;
  localparam int unsigned ClrBits  = $clog2(ClrDepth + 1);

  map_entry_t   map_mem   [PageCount];
  owner_entry_t owner_mem [FrameCount];
  map_entry_t   map_rdata_q;
  owner_entry_t owner_rdata_q;
  logic [ClrBits-1:0] clr_q;
  logic               clearing;

  assign clearing = clr_q < ClrBits'(ClrDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + ClrBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      map_mem[clr_q[PageBits-1:0]] <= '0;
    end else if (map_wr_i.en) begin
      map_mem[map_wr_i.addr] <= map_wr_i.data;
    end
    map_rdata_q <= map_mem[map_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      owner_mem[clr_q[FrameBits-1:0]] <= '0;
    end else if (owner_wr_i.en) begin
      owner_mem[owner_wr_i.addr] <= owner_wr_i.data;
    end
    owner_rdata_q <= owner_mem[owner_raddr_i];
  end

  assign map_rdata_o   = map_rdata_q;
  assign owner_rdata_o = owner_rdata_q;
  assign clearing_o    = clearing;

  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !map_wr_i.en && !owner_wr_i.en)
    else $error("Page map written during the clearing pass.");

endmodule

// ===== rtl/tlb_fifo_page_translator.sv =====
`timescale 1ns / 1ps
// A TLB hit or a page table hit goes from the lookup state straight to the done state, a
// page fault passes the invalidate and map states first; the next transaction is taken
// only once the result is loaded into the output register, which waits while the output
// is stalled. The page fault path is set by the single write port of the page map memory.
// Reset is asynchronous and active low; after it, a clearing pass over each entry empties
// the page map and the frame owner memory before the first transaction is accepted.
module tlb_fifo_page_translator import tfpt_pkg::*; #(
  parameter int unsigned TlbEntries = TlbEntriesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  output logic [PdataBits-1:0] prdata,
  output logic                 pready,
  tfpt_req_if.sink             req_i,
  tfpt_rsp_if.source           rsp_o
);

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StLook  = 6'b000100,
    StInv   = 6'b001000,
    StMap   = 6'b010000,
    StDone  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [FrameBits-1:0] nf_q, nf_d;
  logic [AddrBits-1:0]  addr_q;
  xlat_t                res_q, res_d;
  xlat_t                out_q;
  logic                 out_valid_q;
  logic                 out_load;
  logic                 accept;

  logic [CountBits-1:0] frame_count;
  logic [CountBits-1:0] frame_limit;
  logic [CountBits-1:0] nf_inc;

  logic                 clearing;
  logic [PageBits-1:0]  map_raddr;
  map_wr_t              map_wr;
  map_entry_t           map_rdata;
  owner_wr_t            owner_wr;
  owner_entry_t         owner_rdata;
  tlb_lookup_t          tlb_lookup;
  tlb_push_t            tlb_push;
  tlb_result_t          tlb_res;

  logic [PageBits-1:0]   page;
  logic [OffsetBits-1:0] offset;

  tfpt_cfg_apb u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_count_o (frame_count)
  );

  tfpt_tlb #(
    .TlbEntries (TlbEntries)
  ) u_tlb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .lookup_i (tlb_lookup),
    .push_i   (tlb_push),
    .result_o (tlb_res)
  );

  tfpt_page_mem u_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .map_raddr_i   (map_raddr),
    .map_wr_i      (map_wr),
    .map_rdata_o   (map_rdata),
    .owner_raddr_i (nf_q),
    .owner_wr_i    (owner_wr),
    .owner_rdata_o (owner_rdata),
    .clearing_o    (clearing)
  );

  assign page   = addr_q[AddrBits-1:OffsetBits];
  assign offset = addr_q[OffsetBits-1:0];

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  assign tlb_lookup.en  = accept;
  assign tlb_lookup.tag = req_i.logical_address[AddrBits-1:OffsetBits];

  assign map_raddr = (state_q == StIdle) ? req_i.logical_address[AddrBits-1:OffsetBits]
                                         : owner_rdata.page;

  always_comb begin
    if (frame_count == '0) begin
      frame_limit = FrameCountMin;
    end else if (frame_count > FrameCountMax) begin
      frame_limit = FrameCountMax;
    end else begin
      frame_limit = frame_count;
    end
  end

  assign nf_inc   = {1'b0, nf_q} + CountBits'(1);
  assign out_load = (state_q == StDone) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d  = state_q;
    nf_d     = nf_q;
    res_d    = res_q;
    tlb_push = '0;
    map_wr   = '0;
    owner_wr = '0;
    case (state_q)
      StClear: begin
        if (!clearing) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = StLook;
        end
      end
      StLook: begin
        if (tlb_res.hit) begin
          res_d   = '{physical_address: {tlb_res.frame, offset}, tlb_hit: 1'b1,
                      page_fault: 1'b0};
          state_d = StDone;
        end else if (map_rdata.valid) begin
          tlb_push = '{en: 1'b1, tag: page, frame: map_rdata.frame};
          res_d    = '{physical_address: {map_rdata.frame, offset}, tlb_hit: 1'b0,
                       page_fault: 1'b0};
          state_d  = StDone;
        end else begin
          state_d = StInv;
        end
      end
      StInv: begin
        // The page that last took this frame is dropped only if it still holds it.
        map_wr.en   = owner_rdata.valid && map_rdata.valid && (map_rdata.frame == nf_q);
        map_wr.addr = owner_rdata.page;
        map_wr.data = '0;
        state_d     = StMap;
      end
      StMap: begin
        map_wr   = '{en: 1'b1, addr: page, data: '{valid: 1'b1, frame: nf_q}};
        owner_wr = '{en: 1'b1, addr: nf_q, data: '{valid: 1'b1, page: page}};
        tlb_push = '{en: 1'b1, tag: page, frame: nf_q};
        res_d    = '{physical_address: {nf_q, offset}, tlb_hit: 1'b0, page_fault: 1'b1};
        nf_d     = (nf_inc >= frame_limit) ? '0 : nf_inc[FrameBits-1:0];
        state_d  = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      nf_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      addr_q <= req_i.logical_address;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.physical_address = out_q.physical_address;
  assign rsp_o.tlb_hit          = out_q.tlb_hit;
  assign rsp_o.page_fault       = out_q.page_fault;

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.tlb_hit && rsp_o.page_fault))
    else $error("Hit and fault flagged on the same transaction.");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !req_i.ready)
    else $error("Transaction accepted during the clearing pass.");

  a_accept_starts_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StLook))
    else $error("Accepted transaction did not start a lookup.");

  a_map_marks_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMap) |=> (res_q.page_fault && !res_q.tlb_hit))
    else $error("Frame assignment did not produce a fault result.");

endmodule

// ===== tb/tfpt_checker.sv =====
`timescale 1ns / 1ps

module tfpt_checker import tfpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [PdataBits-1:0] pwdata,
  tfpt_req_if                  req,
  tfpt_rsp_if                  rsp,
  output int                   mismatches_o,
  output int                   translations_o
);

  typedef struct {
    logic [AddrBits-1:0] logical_address;
    xlat_t               xlat;
  } expected_xlat_t;

  logic [PageBits-1:0]  tlb_tag   [TlbEntriesDefault];
  logic [FrameBits-1:0] tlb_frame [TlbEntriesDefault];
  logic                 tlb_live  [TlbEntriesDefault];
  map_entry_t           page_map  [PageCount];
  logic [FrameBits-1:0] next_frame;
  logic [CountBits-1:0] frame_count;
  expected_xlat_t       expected_xlats [$];

  function automatic xlat_t translate_address(input logic [AddrBits-1:0] la);
    logic [PageBits-1:0]  page;
    logic [FrameBits-1:0] frame;
    logic                 hit;
    logic                 fault;
    int unsigned          limit;
    int unsigned          following;
    xlat_t                xlat;
    page  = la[AddrBits-1:OffsetBits];
    frame = '0;
    hit   = 1'b0;
    fault = 1'b0;
    // The newest slot wins when a page appears more than once.
    for (int s = TlbEntriesDefault - 1; s >= 0; s--) begin
      if (!hit && tlb_live[s] && tlb_tag[s] == page) begin
        frame = tlb_frame[s];
        hit   = 1'b1;
      end
    end
    if (!hit) begin
      if (page_map[page].valid) begin
        frame = page_map[page].frame;
      end else begin
        fault = 1'b1;
        frame = next_frame;
        for (int p = 0; p < PageCount; p++) begin
          if (page_map[p].valid && page_map[p].frame == frame) begin
            page_map[p] = '0;
          end
        end
        if (frame_count == '0) begin
          limit = 1;
        end else if (frame_count > FrameCountMax) begin
          limit = FrameCountMax;
        end else begin
          limit = frame_count;
        end
        following = next_frame + 1;
        if (following >= limit) begin
          following = 0;
        end
        next_frame = FrameBits'(following);
        page_map[page].valid = 1'b1;
        page_map[page].frame = frame;
      end
      for (int s = 0; s < TlbEntriesDefault - 1; s++) begin
        tlb_tag[s]   = tlb_tag[s+1];
        tlb_frame[s] = tlb_frame[s+1];
        tlb_live[s]  = tlb_live[s+1];
      end
      tlb_tag[TlbEntriesDefault-1]   = page;
      tlb_frame[TlbEntriesDefault-1] = frame;
      tlb_live[TlbEntriesDefault-1]  = 1'b1;
    end
    xlat.physical_address = {frame, la[OffsetBits-1:0]};
    xlat.tlb_hit          = hit;
    xlat.page_fault       = fault;
    return xlat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    expected_xlat_t want;
    if (!rst_ni) begin
      for (int s = 0; s < TlbEntriesDefault; s++) begin
        tlb_tag[s]   = '0;
        tlb_frame[s] = '0;
        tlb_live[s]  = 1'b0;
      end
      for (int p = 0; p < PageCount; p++) begin
        page_map[p] = '0;
      end
      next_frame  = '0;
      frame_count = FrameCountReset;
      expected_xlats.delete();
      mismatches_o   <= 0;
      translations_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && int'(paddr >> 2) == int'(RegFrameCount)) begin
        frame_count = pwdata[CountBits-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        translations_o <= translations_o + 1;
        if (expected_xlats.size() == 0) begin
          $display("%0t: unexpected translation pa=%h hit=%b fault=%b", $time,
                   rsp.physical_address, rsp.tlb_hit, rsp.page_fault);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_xlats.pop_front();
          if (rsp.physical_address !== want.xlat.physical_address ||
              rsp.tlb_hit !== want.xlat.tlb_hit || rsp.page_fault !== want.xlat.page_fault) begin
            $display("%0t: address %h expected pa=%h hit=%b fault=%b, got pa=%h hit=%b fault=%b",
                     $time, want.logical_address, want.xlat.physical_address,
                     want.xlat.tlb_hit, want.xlat.page_fault, rsp.physical_address,
                     rsp.tlb_hit, rsp.page_fault);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        want.logical_address = req.logical_address;
        want.xlat            = translate_address(req.logical_address);
        expected_xlats.push_back(want);
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tfpt_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseCount   = 11;
  localparam int unsigned PhaseItems   = 145;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HotMax       = 24;

  localparam logic [PaddrBits-1:0] FrameCountAddr = PaddrBits'(4 * int'(RegFrameCount));
  localparam logic [PaddrBits-1:0] SpareAddr      = PaddrBits'(4);

  localparam logic [CountBits-1:0] CountPlan [PhaseCount] = '{
    9'd3, 9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd300, 9'd17, 9'd128, 9'd255, 9'd5
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata;
  logic [PdataBits-1:0] prdata;
  logic                 pready;

  tfpt_req_if req_if ();
  tfpt_rsp_if rsp_if ();

  int          sender_idle_pct = 0;
  int          stall_pct       = 0;
  logic        hold_start      = 1'b0;
  int          sent            = 0;
  int          mismatches;
  int          translations;
  int unsigned cycles;

  logic [PageBits-1:0] hot_pages [HotMax];
  int unsigned         hot_count = 1;

  tlb_fifo_page_translator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  tfpt_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .req           (req_if),
    .rsp           (rsp_if),
    .mismatches_o  (mismatches),
    .translations_o(translations)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_address(input logic [AddrBits-1:0] la);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.logical_address <= la;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (translations != sent);
  endtask

  task automatic cfg_write(input logic [PaddrBits-1:0] addr, input logic [PdataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly a small working set, so that the TLB and the page map both hit, with
  // the extreme pages and wholly random pages mixed in.
  function automatic logic [AddrBits-1:0] pick_address();
    logic [PageBits-1:0] page;
    int unsigned         roll;
    roll = $urandom_range(99);
    if (roll < 65) begin
      page = hot_pages[$urandom_range(hot_count - 1)];
    end else if (roll < 70) begin
      page = roll[0] ? '1 : '0;
    end else begin
      page = PageBits'($urandom);
    end
    return {page, OffsetBits'($urandom)};
  endfunction

  initial begin
    rst_ni                 <= 1'b0;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_if.valid           <= 1'b0;
    req_if.logical_address <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Page zero must fault first even though the checker's TLB tags start out zeroed.
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    send_address(16'hFF00);
    send_address(16'h8001);
    send_address(16'h7FFE);
    send_address(16'h5555);
    send_address(16'hAAAA);
    for (int p = 16; p < 32; p++) begin
      send_address({PageBits'(p), OffsetBits'(p * 7)});
    end
    send_address(16'h0012);
    send_address(16'hFFED);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_drained();
      repeat (SettleCycles) @(posedge clk_i);
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          stall_pct       = 0;
        end
        1: begin
          sender_idle_pct = 54;
          stall_pct       = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct       = 54;
        end
        default: begin
          sender_idle_pct = 15;
          stall_pct       = 15;
        end
      endcase
      cfg_write(FrameCountAddr, {23'($urandom), CountPlan[phase]});
      if (phase == 5) begin
        @(posedge clk_i);
        cfg_write(SpareAddr, $urandom);
      end
      hot_count = $urandom_range(HotMax, 3);
      for (int h = 0; h < HotMax; h++) begin
        hot_pages[h] = PageBits'($urandom);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (phase == 2 && n == 20) begin
          hold_start = 1'b1;
        end
        if (phase == 4 && n == 70) begin
          wait_drained();
        end
        send_address(pick_address());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
